// ===== sv/sirta_pkg.sv =====
// ----------------------------------------------------------------------------
// sirta_pkg
// Shared types, constants and helpers for the radix ASCII converter.
// ----------------------------------------------------------------------------
package sirta_pkg;

  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A     = 7'h41;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SIGN,
    BK_EMIT
  } back_state_t;

  // Clamp a raw register write into the usable base range.
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] v;
    v = r;
    if (r < RADIX_MIN) begin
      v = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      v = RADIX_MAX;
    end
    return v;
  endfunction

  // Digit value 0..35 to '0'-'9' or 'A'-'Z'.
  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 6'd10) begin
      c = ASCII_ZERO + {1'b0, d};
    end else begin
      c = ASCII_A - 7'd10 + {1'b0, d};
    end
    return c;
  endfunction

endpackage

// ===== sv/sirta_front.sv =====
// ----------------------------------------------------------------------------
// sirta_front
// Accepts input words, splits them into sign and magnitude and holds them in
// a two-entry queue for the conversion sequencer.
// ----------------------------------------------------------------------------
module sirta_front #(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic signed [WORD_BITS-1:0] number,
  output logic                        q_valid,
  output logic                        q_neg,
  output logic [WORD_BITS-1:0]        q_mag,
  input  logic                        q_pop
);
  import sirta_pkg::*;

  logic                 ent_neg [2];
  logic [WORD_BITS-1:0] ent_mag [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;
  logic [WORD_BITS-1:0] raw;
  logic                 in_neg;
  logic [WORD_BITS-1:0] in_mag;
  logic                 do_push;
  logic                 do_pop;

  // Magnitude taken as unsigned, so the most negative value is exact.
  assign raw     = WORD_BITS'(number);
  assign in_neg  = raw[WORD_BITS-1];
  assign in_mag  = in_neg ? (~raw + WORD_BITS'(1)) : raw;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_neg   = ent_neg[rd_ptr];
  assign q_mag   = ent_mag[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_neg[wr_ptr] <= in_neg;
      ent_mag[wr_ptr] <= in_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== sv/sirta_div.sv =====
// ----------------------------------------------------------------------------
// sirta_div
// Iterative divide by the radix: four quotient bits per cycle, giving one
// digit (remainder) and the remaining value (quotient) per run.
// ----------------------------------------------------------------------------
module sirta_div #(
  parameter int WORD_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [WORD_BITS-1:0]             dividend,
  input  logic [sirta_pkg::RADIX_W-1:0]    radix,
  output logic                             done,
  output logic [WORD_BITS-1:0]             quotient,
  output logic [sirta_pkg::RADIX_W-1:0]    remainder
);
  import sirta_pkg::*;

  localparam int PW    = ((WORD_BITS + 3) / 4) * 4;
  localparam int NSTEP = PW / 4;
  localparam int CW    = $clog2(NSTEP + 1);

  logic [PW-1:0]      acc;
  logic [PW-1:0]      acc_next;
  logic [RADIX_W-1:0] rem;
  logic [RADIX_W-1:0] rem_next;
  logic [CW-1:0]      cnt;
  logic               busy;

  // Four restoring steps; the dividend drains from the top of acc while
  // quotient bits fill in from the bottom.
  always_comb begin
    logic [PW-1:0]      a;
    logic [RADIX_W-1:0] r;
    logic [RADIX_W:0]   t;
    a = acc;
    r = rem;
    for (int k = 0; k < 4; k++) begin
      t = {r, a[PW-1]};
      a = {a[PW-2:0], 1'b0};
      if (t >= {1'b0, radix}) begin
        t    = t - {1'b0, radix};
        a[0] = 1'b1;
      end
      r = t[RADIX_W-1:0];
    end
    acc_next = a;
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NSTEP);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= PW'(dividend);
      rem <= '0;
    end else if (busy) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  assign quotient  = acc[WORD_BITS-1:0];
  assign remainder = rem;

endmodule

// ===== sv/sirta_back.sv =====
// ----------------------------------------------------------------------------
// sirta_back
// Conversion sequencer: runs the divider once per digit, stacks the digits,
// then sends a minus sign for a negative value and the digits most
// significant first through an output register.
// ----------------------------------------------------------------------------
module sirta_back #(
  parameter int WORD_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  logic                             q_neg,
  input  logic [WORD_BITS-1:0]             q_mag,
  output logic                             q_pop,
  input  logic [sirta_pkg::RADIX_W-1:0]    radix,
  input  logic                             pop,
  output logic                             empty,
  output logic [sirta_pkg::CHAR_W-1:0]     character,
  output logic                             last_char
);
  import sirta_pkg::*;

  localparam int DW = $clog2(WORD_BITS + 1);

  back_state_t          state;
  back_state_t          state_next;
  logic                 neg;
  logic [RADIX_W-1:0]   stk [WORD_BITS];
  logic [DW-1:0]        depth;
  logic                 out_valid;
  logic                 out_free;
  logic                 out_load;
  logic [CHAR_W-1:0]    out_char;
  logic                 out_last;
  logic                 dig_push;
  logic                 dig_pop;
  logic                 div_start;
  logic [WORD_BITS-1:0] div_dividend;
  logic                 div_done;
  logic [WORD_BITS-1:0] div_quo;
  logic [RADIX_W-1:0]   div_rem;
  logic                 quo_zero;

  sirta_div #(
    .WORD_BITS (WORD_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .radix     (radix),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign quo_zero = (div_quo == '0);
  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) state_next = BK_DIV;
      end
      BK_DIV: begin
        if (div_done && quo_zero) state_next = neg ? BK_SIGN : BK_EMIT;
      end
      BK_SIGN: begin
        if (out_free) state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free && depth == DW'(1)) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    div_start    = 1'b0;
    div_dividend = div_quo;
    dig_push     = 1'b0;
    dig_pop      = 1'b0;
    out_load     = 1'b0;
    out_char     = digit_glyph(stk[0]);
    out_last     = 1'b0;
    unique case (state)
      BK_IDLE: begin
        q_pop        = q_valid;
        div_start    = q_valid;
        div_dividend = q_mag;
      end
      BK_DIV: begin
        dig_push  = div_done;
        div_start = div_done && !quo_zero;
      end
      BK_SIGN: begin
        out_load = out_free;
        out_char = ASCII_MINUS;
      end
      BK_EMIT: begin
        out_load = out_free;
        dig_pop  = out_free;
        out_last = (depth == DW'(1));
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      depth     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (dig_push) begin
        depth <= depth + DW'(1);
      end else if (dig_pop) begin
        depth <= depth - DW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Digit stack: newest digit always at the bottom entry.
  always_ff @(posedge clk) begin
    if (dig_push) begin
      stk[0] <= div_rem;
      for (int i = 1; i < WORD_BITS; i++) begin
        stk[i] <= stk[i-1];
      end
    end else if (dig_pop) begin
      for (int i = 0; i < WORD_BITS - 1; i++) begin
        stk[i] <= stk[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      neg <= q_neg;
    end
    if (out_load) begin
      character <= out_char;
      last_char <= out_last;
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(WORD_BITS))
    else $error("digit stack overflow");

  a_emit_has_digit: assert property (@(posedge clk) disable iff (rst)
    state == BK_EMIT |-> depth != '0)
    else $error("emitting from an empty digit stack");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == BK_DIV)
    else $error("divider finished outside the divide phase");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    out_load && out_last |=> state == BK_IDLE && depth == '0)
    else $error("last character sent with digits left");

endmodule

// ===== sv/signed_int_to_radix_ascii_core.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_radix_ascii_core
// Signed integer to ASCII text in a base from 2 to 36, one character per word.
// ----------------------------------------------------------------------------
// Each digit takes one divider run, which resolves four quotient bits per
// cycle; characters then leave one per cycle while the reader keeps popping.
// A two-entry input queue takes new words while the sequencer is busy.
// Reset empties the queue and output register and sets the radix to 10.
module signed_int_to_radix_ascii_core #(
  parameter int WORD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic signed [WORD_BITS-1:0]    number,
  input  logic                           pop,
  output logic                           empty,
  output logic [sirta_pkg::CHAR_W-1:0]   character,
  output logic                           last_char,
  input  logic                           radix_we,
  input  logic [sirta_pkg::RADIX_W-1:0]  radix
);
  import sirta_pkg::*;

  logic [RADIX_W-1:0]   base;
  logic                 q_valid;
  logic                 q_neg;
  logic [WORD_BITS-1:0] q_mag;
  logic                 q_pop;

  // Hold the clamped base so the divider sees only 2..36.
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= RADIX_RESET;
    end else if (radix_we) begin
      base <= clamp_radix(radix);
    end
  end

  sirta_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .number  (number),
    .q_valid (q_valid),
    .q_neg   (q_neg),
    .q_mag   (q_mag),
    .q_pop   (q_pop)
  );

  sirta_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_neg     (q_neg),
    .q_mag     (q_mag),
    .q_pop     (q_pop),
    .radix     (base),
    .pop       (pop),
    .empty     (empty),
    .character (character),
    .last_char (last_char)
  );

endmodule
